>>> hdl/lzc_pkg.sv
`timescale 1ns / 1ps
package lzc_pkg;
   localparam int CODE_BITS   = 16;
   localparam int DIGIT_BASE  = 128;
   localparam int DIGIT_BITS  = $clog2(DIGIT_BASE);
   localparam int BYTE_W      = 8;
   localparam int LIMIT_W     = 16;
   localparam int KEY_W       = CODE_BITS + BYTE_W;
   localparam int DEPTH       = 1 << CODE_BITS;
   localparam int CODE_MAX    = DEPTH - 1;
   localparam int EPOCH_W     = 8;
   localparam int EPOCH_MAX   = (1 << EPOCH_W) - 1;
   localparam int WORD_W      = EPOCH_W + KEY_W + CODE_BITS;
   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [EPOCH_W-1:0]   epoch_type;

   typedef struct packed {
      epoch_type epoch;
      key_type   key;
      code_type  code;
   } entry_type;
endpackage

>>> hdl/lzc_if.sv
`timescale 1ns / 1ps
interface lzc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;
   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface lzc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_done;
   modport source (output valid, output out_byte, output run_last, output stream_done,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input stream_done,
                 output ready);
endinterface

>>> hdl/lzc_front.sv
`timescale 1ns / 1ps
module lzc_front (
   input logic clock,
   input logic reset,
   lzc_req_if.sink   req_if,
   lzc_req_if.source q_if
);
   import lzc_pkg::*;

   logic [BYTE_W-1:0] byte_ff [2];
   logic [BYTE_W-1:0] byte_in [2];
   logic              end_ff [2];
   logic              end_in [2];
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign req_if.ready  = (count_ff != 2'd2);
   assign q_if.valid    = (count_ff != 2'd0);
   assign q_if.in_byte  = byte_ff[0];
   assign q_if.stream_end = end_ff[0];
   assign push = req_if.valid && req_if.ready;
   assign pop  = q_if.valid && q_if.ready;

   always_comb begin
      byte_in[0] = byte_ff[0];
      byte_in[1] = byte_ff[1];
      end_in[0]  = end_ff[0];
      end_in[1]  = end_ff[1];
      count_in   = count_ff;
      if (pop) begin
         byte_in[0] = byte_ff[1];
         end_in[0]  = end_ff[1];
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            byte_in[0] = req_if.in_byte;
            end_in[0]  = req_if.stream_end;
         end else begin
            byte_in[1] = req_if.in_byte;
            end_in[1]  = req_if.stream_end;
         end
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

>>> hdl/lzc_engine.sv
`timescale 1ns / 1ps
module lzc_engine (
   input logic clock,
   input logic reset,
   input logic [lzc_pkg::LIMIT_W-1:0] limit,
   lzc_req_if.sink   q_if,
   lzc_rsp_if.source rsp_if
);
   import lzc_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;
   localparam logic [2:0] ST_LIT   = 3'd6;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   logic [2:0]          state_ff, state_in;
   code_type            clr_ff, clr_in;
   epoch_type           epoch_ff, epoch_in;
   code_type            prefix_ff, prefix_in;
   logic [CODE_BITS:0]  next_ff, next_in;
   key_type             key_ff, key_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                end_ff, end_in;
   code_type            slot_ff, slot_in;
   code_type            c_ff, c_in;
   logic                ov_ff, ov_in;
   logic [BYTE_W-1:0]   ob_ff, ob_in;
   logic                ol_ff, ol_in;
   logic                od_ff, od_in;

   logic [31:0]         prod;
   logic                occupied, hit, allow, free, last_digit;
   logic                wr_en;
   code_type            wr_addr;
   entry_type           wr_data;

   assign prod     = 32'(32'(key_ff) * HASH_MULT);
   assign occupied = (rdata_ff.epoch == epoch_ff);
   assign hit      = occupied && (rdata_ff.key == key_ff);
   assign allow    = (next_ff <= (CODE_BITS + 1)'(limit)) &&
                     (next_ff <= (CODE_BITS + 1)'(CODE_MAX));
   assign free     = !ov_ff || rsp_if.ready;
   assign last_digit = ((c_ff >> DIGIT_BITS) == '0);

   assign q_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid     = ov_ff;
   assign rsp_if.out_byte  = ob_ff;
   assign rsp_if.run_last  = ol_ff;
   assign rsp_if.stream_done = od_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      epoch_in  = epoch_ff;
      prefix_in = prefix_ff;
      next_in   = next_ff;
      key_in    = key_ff;
      byte_in   = byte_ff;
      end_in    = end_ff;
      slot_in   = slot_ff;
      c_in      = c_ff;
      ov_in     = ov_ff && !rsp_if.ready;
      ob_in     = ob_ff;
      ol_in     = ol_ff;
      od_in     = od_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_data   = '{epoch: epoch_ff, key: key_ff, code: next_ff[CODE_BITS-1:0]};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '{epoch: '0, key: '0, code: '0};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == code_type'(CODE_MAX)) begin
               epoch_in = epoch_type'(1);
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_if.valid) begin
               byte_in  = q_if.in_byte;
               end_in   = q_if.stream_end;
               key_in   = {prefix_ff, q_if.in_byte};
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            slot_in  = prod[31 -: CODE_BITS];
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (occupied && !hit) begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_READ;
            end else if (hit && !end_ff) begin
               prefix_in = rdata_ff.code;
               state_in  = ST_IDLE;
            end else begin
               if (!hit && allow) begin
                  wr_en   = 1'b1;
                  next_in = next_ff + 1'b1;
               end
               c_in     = prefix_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (free) begin
               ov_in = 1'b1;
               ol_in = 1'b0;
               od_in = 1'b0;
               if (last_digit) begin
                  ob_in    = BYTE_W'(2 * DIGIT_BASE - 1) - BYTE_W'(c_ff[DIGIT_BITS-1:0]);
                  state_in = ST_LIT;
               end else begin
                  ob_in = BYTE_W'(c_ff[DIGIT_BITS-1:0]);
                  c_in  = c_ff >> DIGIT_BITS;
               end
            end
         end
         ST_LIT: begin
            if (free) begin
               ov_in     = 1'b1;
               ob_in     = byte_ff;
               ol_in     = 1'b1;
               od_in     = end_ff;
               prefix_in = '0;
               state_in  = ST_IDLE;
               if (end_ff) begin
                  next_in = (CODE_BITS + 1)'(1);
                  if (epoch_ff == epoch_type'(EPOCH_MAX)) begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      slot_ff <= slot_in;
      c_ff    <= c_in;
      ob_ff   <= ob_in;
      ol_ff   <= ol_in;
      od_ff   <= od_in;
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         epoch_ff  <= '0;
         prefix_ff <= '0;
         next_ff   <= (CODE_BITS + 1)'(1);
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         epoch_ff  <= epoch_in;
         prefix_ff <= prefix_in;
         next_ff   <= next_in;
         ov_ff     <= ov_in;
      end
   end

`ifndef SYNTHESIS
   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= (CODE_BITS + 1)'(CODE_MAX + 1))
      else $error("next code out of range");
   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> (epoch_ff != '0))
      else $error("live epoch matches cleared entries");
   a_lit_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(ol_ff) |-> ($past(state_ff) == ST_LIT))
      else $error("literal item outside literal step");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && od_ff) |-> ol_ff)
      else $error("stream end on a code digit");
`endif
endmodule

>>> hdl/lz78_byte_compressor_unit.sv
`timescale 1ns / 1ps
// LZ78 byte compressor. Each byte takes a dequeue, a hash multiply, a memory
// read and a compare, plus a read and compare per extra linear probe of the
// hash memory. A pair leaves as one item per cycle unless the output stalls
// (1 to 3 code digits, then the literal). A two-entry input queue takes items
// until full while the engine works or the output waits. After reset and every
// 255th stream end, a clearing pass sweeps all 65536 entries while no item is
// dequeued; other stream ends retire the dictionary at once by epoch.
module lz78_byte_compressor_unit (
   input logic        clock,
   input logic        reset,
   input logic        csr_wr_en,
   input logic [15:0] csr_wr_data,
   lzc_req_if.sink    req_if,
   lzc_rsp_if.source  rsp_if
);
   import lzc_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   lzc_req_if q_if ();

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '1;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   lzc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_if   (q_if)
   );

   lzc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .limit  (limit_ff),
      .q_if   (q_if),
      .rsp_if (rsp_if)
   );
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import lzc_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_done;
   } out_item_type;

   // is_cfg rows write the limit; n_out < 0 means the output comes from the predictor
   typedef struct {
      bit          is_cfg;
      int          value;
      bit          fin;
      int          n_out;
      logic [7:0]  code_byte;
      logic [7:0]  lit_byte;
   } stim_row_type;

   localparam int IDLE_LIMIT = 200000;
   localparam int SETTLE     = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   lzc_req_if req_if ();
   lzc_rsp_if rsp_if ();

   lz78_byte_compressor_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_if     (req_if),
      .rsp_if     (rsp_if)
   );

   code_type         phrase_dict [key_type];
   code_type         cur_prefix;
   int               next_phrase;
   int               dict_limit;
   out_item_type     pending_out [$];
   int               errors;
   int               tx_pct;
   int               rx_pct;
   int               hold_req;
   int               hold_left;
   int               idle_cycles;
   int               row_tag;
   int               tag_q;
   int               base_q;
   stim_row_type     stim [$];

   initial begin
      req_if.valid = 1'b0;
      req_if.in_byte = '0;
      req_if.stream_end = 1'b0;
      rsp_if.ready = 1'b0;
      row_tag = -1;
      errors = 0;
      tx_pct = 0;
      rx_pct = 0;
      hold_req = 0;
      hold_left = 0;
      idle_cycles = 0;
      dict_limit = 65535;
      cur_prefix = '0;
      next_phrase = 1;
   end

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic predict_pair(input logic [7:0] b, input bit fin);
      key_type key;
      int      c;
      int      d;
      key = {cur_prefix, b};
      if (phrase_dict.exists(key) && !fin) begin
         cur_prefix = phrase_dict[key];
         return;
      end
      if (!phrase_dict.exists(key) && next_phrase <= dict_limit && next_phrase <= CODE_MAX) begin
         phrase_dict[key] = code_type'(next_phrase);
         next_phrase++;
      end
      c = cur_prefix;
      forever begin
         d = c % DIGIT_BASE;
         c = c / DIGIT_BASE;
         if (c == 0) begin
            pending_out.push_back('{8'(2 * DIGIT_BASE - 1 - d), 1'b0, 1'b0});
            break;
         end
         pending_out.push_back('{8'(d), 1'b0, 1'b0});
      end
      pending_out.push_back('{b, 1'b1, fin});
      cur_prefix = '0;
      if (fin) begin
         phrase_dict.delete();
         next_phrase = 1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         tag_q = row_tag;
         if (tag_q >= 0 && stim[tag_q].n_out >= 0) begin
            // typed row: advance the model state, then replace its output
            base_q = pending_out.size();
            predict_pair(req_if.in_byte, req_if.stream_end);
            while (pending_out.size() > base_q)
               void'(pending_out.pop_back());
            if (stim[tag_q].n_out == 2) begin
               pending_out.push_back('{stim[tag_q].code_byte, 1'b0, 1'b0});
               pending_out.push_back('{stim[tag_q].lit_byte, 1'b1, stim[tag_q].fin});
            end
         end else begin
            predict_pair(req_if.in_byte, req_if.stream_end);
         end
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_out.size() == 0) begin
            report_mismatch("unexpected item, out_byte", rsp_if.out_byte, -1);
         end else begin
            out_item_type want;
            want = pending_out.pop_front();
            if (rsp_if.out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_if.out_byte, want.out_byte);
            if (rsp_if.run_last !== want.run_last)
               report_mismatch("run_last", rsp_if.run_last, want.run_last);
            if (rsp_if.stream_done !== want.stream_done)
               report_mismatch("stream_done", rsp_if.stream_done, want.stream_done);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_req = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("lz78_byte_compressor_unit test failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit fin, input int tag);
      if ($urandom_range(99) < tx_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_pct) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.stream_end <= fin;
      row_tag <= tag;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_outputs();
      req_if.valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input int value);
      drain_outputs();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= 16'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dict_limit = value & 16'hFFFF;
   endtask

   int        left_in_stream;
   int        alpha_base;
   int        alpha_size;
   bit        long_done;
   int        limits [4] = '{65535, 40, 65535, 5};
   int        tx_mode [4] = '{0, 57, 0, 18};
   int        rx_mode [4] = '{0, 0, 57, 18};
   logic [7:0] b;
   bit         fin;

   initial begin
      stim = '{
         '{0, 8'h00, 0,  2, 8'd255, 8'h00},
         '{0, 8'hFF, 0,  2, 8'd255, 8'hFF},
         '{0, 8'h00, 0,  0, 8'd0,   8'h00},
         '{0, 8'hFF, 0,  2, 8'd254, 8'hFF},
         '{0, 8'h00, 0,  0, 8'd0,   8'h00},
         '{0, 8'hFF, 1,  2, 8'd254, 8'hFF},
         '{0, 8'h80, 1,  2, 8'd255, 8'h80},
         '{1, 0,     0, -1, 8'd0,   8'h00},
         '{0, 8'h41, 0,  2, 8'd255, 8'h41},
         '{0, 8'h41, 0,  2, 8'd255, 8'h41},
         '{0, 8'h7F, 1,  2, 8'd255, 8'h7F},
         '{1, 1,     0, -1, 8'd0,   8'h00},
         '{0, 8'h41, 0,  2, 8'd255, 8'h41},
         '{0, 8'h41, 0,  0, 8'd0,   8'h00},
         '{0, 8'h41, 0,  2, 8'd254, 8'h41},
         '{0, 8'h41, 0,  0, 8'd0,   8'h00},
         '{0, 8'h42, 0, -1, 8'd0,   8'h00},
         '{1, 65535, 0, -1, 8'd0,   8'h00},
         '{0, 8'h42, 0, -1, 8'd0,   8'h00},
         '{0, 8'h43, 1, -1, 8'd0,   8'h00},
         '{0, 8'h01, 0, -1, 8'd0,   8'h00},
         '{0, 8'h02, 0, -1, 8'd0,   8'h00},
         '{1, 1,     0, -1, 8'd0,   8'h00},
         '{0, 8'h01, 0, -1, 8'd0,   8'h00},
         '{0, 8'h01, 0, -1, 8'd0,   8'h00},
         '{0, 8'h03, 1, -1, 8'd0,   8'h00}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim.size(); i++) begin
         if (stim[i].is_cfg)
            write_limit(stim[i].value);
         else
            send_byte(8'(stim[i].value), stim[i].fin, i);
      end

      left_in_stream = 0;
      long_done = 0;
      for (int p = 0; p < 4; p++) begin
         write_limit(limits[p]);
         tx_pct = tx_mode[p];
         rx_pct = rx_mode[p];
         if (p == 1) hold_req = 1;
         for (int k = 0; k < 62; k++) begin
            if (p == 2 && k == 30) drain_outputs();
            if (left_in_stream == 0) begin
               if (!long_done) begin
                  left_in_stream = 140;
                  long_done = 1;
                  alpha_size = 16;
               end else begin
                  left_in_stream = $urandom_range(1, 30);
                  alpha_size = ($urandom_range(3) == 0) ? 256 : $urandom_range(2, 4);
               end
               alpha_base = $urandom_range(0, 256 - alpha_size);
            end
            if ($urandom_range(9) == 0)
               b = 8'($urandom_range(255));
            else
               b = 8'(alpha_base + $urandom_range(alpha_size - 1));
            left_in_stream--;
            fin = (left_in_stream == 0) || ($urandom_range(99) == 0);
            if (fin) left_in_stream = 0;
            send_byte(b, fin, -1);
         end
      end

      drain_outputs();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pending_out.size() == 0) begin
         $display("lz78_byte_compressor_unit test passed");
      end else begin
         $display("lz78_byte_compressor_unit test failed");
      end
      $finish;
   end
endmodule
